// ===== hw/rtl/pcibp_pkg.sv =====
// Package for the unaligned PER bit packer: transaction payload types,
// operation codes, command types between the front and back parts, and sizing constants.
// No dependencies.
package pcibp_pkg;

  // Largest constrained-integer field, in bits; wider ranges are rejected.
  localparam int MaxIntBits = 20;
  // Largest raw bit string, in bits; clipped to the 32-bit field.
  localparam int MaxRawBits = 32;

  localparam int WordW  = 32;
  localparam int OctetW = 8;
  localparam int NbitsW = 6;
  localparam int RawCap = (MaxRawBits < WordW) ? MaxRawBits : WordW;
  // Bit gathering buffer: up to seven pending bits plus one full word.
  localparam int BufW   = OctetW + WordW;
  localparam int TotW   = $clog2(BufW);

  localparam int QueueDepth = 4;
  localparam int QPtrW      = $clog2(QueueDepth);
  localparam int QCntW      = $clog2(QueueDepth + 1);

  localparam logic [1:0] OP_INT   = 2'd0;
  localparam logic [1:0] OP_RAW   = 2'd1;
  localparam logic [1:0] OP_FLUSH = 2'd2;

  typedef struct packed {
    logic [1:0]         op;
    logic signed [31:0] int_value;
    logic signed [31:0] lower_bound;
    logic signed [31:0] upper_bound;
    logic [31:0]        raw_bits;
    logic [5:0]         raw_width;
  } in_item_t;

  typedef struct packed {
    logic [7:0] octet;
    logic       last;
    logic       from_flush;
    logic       range_error;
  } out_item_t;

  typedef enum logic [1:0] {
    KIND_APPEND,
    KIND_ERROR,
    KIND_FLUSH
  } kind_e;

  // Bits of an append command are left-aligned: the first bit sent is bit 31.
  typedef struct packed {
    kind_e             kind;
    logic [NbitsW-1:0] nbits;
    logic [WordW-1:0]  bits;
  } cmd_t;

endpackage

// ===== hw/rtl/per_constrained_integer_bit_packer.sv =====
// Top level of the unaligned PER bit packer: front classifier, command queue,
// and octet-building back part. Uses pcibp_pkg, pcibp_front, pcibp_queue, pcibp_back.
//
//   Channel  | Handshake                  | Payload
//   ---------+----------------------------+------------------------------
//   input    | in_valid_i / in_ready_o    | in_item_i  (pcibp_pkg::in_item_t)
//   output   | out_valid_o / out_ready_i  | out_item_o (pcibp_pkg::out_item_t)
//
// The front takes one transaction per cycle, unless a full queue holds it,
// into a two-stage path (bound ordering and subtraction, then field sizing
// and alignment) and queues one command per transaction that carries bits,
// a range error or a flush. The back takes a command only while fewer than
// eight bits are gathered and sends each completed octet through the output
// register, one octet per cycle while the receiver does not stall it.
// Reset is asynchronous and active low; it clears the pending bits and empties
// the queue and pipeline.
// A stalled output holds the back; the queue then fills and in_ready_o drops.
module per_constrained_integer_bit_packer (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  pcibp_pkg::in_item_t  in_item_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output pcibp_pkg::out_item_t out_item_o
);
  import pcibp_pkg::*;

  // Commands from the front, into the queue.
  cmd_t fq_cmd;
  logic fq_valid, fq_ready;
  // Commands from the queue, into the back.
  cmd_t qb_cmd;
  logic qb_valid, qb_pop;

  // Classifies each transaction: append bits, report a range error, or flush.
  pcibp_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_item_i   (in_item_i),
    .cmd_valid_o (fq_valid),
    .cmd_ready_i (fq_ready),
    .cmd_o       (fq_cmd)
  );

  // Decouples the front from output stalls seen by the back.
  pcibp_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (fq_valid && fq_ready),
    .wdata_i     (fq_cmd),
    .not_full_o  (fq_ready),
    .pop_i       (qb_pop),
    .not_empty_o (qb_valid),
    .rdata_o     (qb_cmd)
  );

  // Gathers bits MSB first and sends each completed octet.
  pcibp_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (qb_valid),
    .cmd_i       (qb_cmd),
    .cmd_pop_o   (qb_pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_item_o  (out_item_o)
  );

endmodule

// ===== hw/rtl/pcibp_front.sv =====
// Front part of the bit packer: accepts input transactions, orders the bounds,
// and turns each operation into an append, error or flush command. Uses pcibp_pkg.
module pcibp_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  pcibp_pkg::in_item_t in_item_i,
  output logic                cmd_valid_o,
  input  logic                cmd_ready_i,
  output pcibp_pkg::cmd_t     cmd_o
);
  import pcibp_pkg::*;

  // Stage one: bound ordering and the two subtractions.
  logic              s1_valid_q, s1_valid_d;
  logic [1:0]        s1_op_q;
  logic [WordW-1:0]  s1_diff_q, s1_offset_q, s1_raw_q;
  logic [5:0]        s1_width_q;

  logic              swap;
  logic [WordW-1:0]  diff_d, offset_d;

  always_comb begin
    swap     = in_item_i.lower_bound > in_item_i.upper_bound;
    diff_d   = swap ? WordW'(in_item_i.lower_bound - in_item_i.upper_bound)
                    : WordW'(in_item_i.upper_bound - in_item_i.lower_bound);
    offset_d = swap ? WordW'(in_item_i.int_value - in_item_i.upper_bound)
                    : WordW'(in_item_i.int_value - in_item_i.lower_bound);
  end

  // Stage two: field size, clipping and left alignment.
  logic [NbitsW-1:0] need, rawn, n;
  logic [WordW-1:0]  src;
  logic              s1_adv;

  always_comb begin
    need = '0;
    for (int i = 0; i < WordW; i++) begin
      if (s1_diff_q[i]) begin
        need = NbitsW'(i + 1);
      end
    end
    rawn = (s1_width_q > NbitsW'(RawCap)) ? NbitsW'(RawCap) : s1_width_q;

    cmd_valid_o = 1'b0;
    cmd_o.kind  = KIND_APPEND;
    n           = '0;
    src         = s1_raw_q;
    case (s1_op_q)
      OP_INT: begin
        src = s1_offset_q;
        if (s1_diff_q != '0) begin
          cmd_valid_o = s1_valid_q;
          if (need > NbitsW'(MaxIntBits)) begin
            cmd_o.kind = KIND_ERROR;
          end else begin
            n = need;
          end
        end
      end
      OP_RAW: begin
        n           = rawn;
        cmd_valid_o = s1_valid_q && (rawn != '0);
      end
      OP_FLUSH: begin
        cmd_o.kind  = KIND_FLUSH;
        cmd_valid_o = s1_valid_q;
      end
      default: begin
        cmd_valid_o = 1'b0;
      end
    endcase
    cmd_o.nbits = n;
    cmd_o.bits  = (n == '0) ? '0 : (src << (NbitsW'(WordW) - n));

    s1_adv     = !cmd_valid_o || cmd_ready_i;
    in_ready_o = !s1_valid_q || s1_adv;
    s1_valid_d = in_ready_o ? in_valid_i : s1_valid_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= s1_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      s1_op_q     <= in_item_i.op;
      s1_diff_q   <= diff_d;
      s1_offset_q <= offset_d;
      s1_raw_q    <= in_item_i.raw_bits;
      s1_width_q  <= in_item_i.raw_width;
    end
  end

endmodule

// ===== hw/rtl/pcibp_queue.sv =====
// Short command queue between the front and back parts of the bit packer.
// Register-based FIFO; uses pcibp_pkg.
module pcibp_queue (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  pcibp_pkg::cmd_t wdata_i,
  output logic            not_full_o,
  input  logic            pop_i,
  output logic            not_empty_o,
  output pcibp_pkg::cmd_t rdata_o
);
  import pcibp_pkg::*;

  cmd_t             entry_q [QueueDepth];
  logic [QPtrW-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [QCntW-1:0] cnt_q, cnt_d;

  always_comb begin
    not_full_o  = cnt_q != QCntW'(QueueDepth);
    not_empty_o = cnt_q != '0;
    rdata_o     = entry_q[rd_ptr_q];
    wr_ptr_d    = wr_ptr_q;
    rd_ptr_d    = rd_ptr_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == QPtrW'(QueueDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == QPtrW'(QueueDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    cnt_d = cnt_q + QCntW'(push_i) - QCntW'(pop_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wr_ptr_q] <= wdata_i;
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i && !pop_i |-> cnt_q < QCntW'(QueueDepth))
    else $error("queue push while full");

  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> cnt_q != '0)
    else $error("queue pop while empty");

  a_count_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i && pop_i |=> $stable(cnt_q))
    else $error("queue count moved on simultaneous push and pop");

endmodule

// ===== hw/rtl/pcibp_back.sv =====
// Back part of the bit packer: gathers command bits into octets and drives
// the output register. Uses pcibp_pkg.
module pcibp_back (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cmd_valid_i,
  input  pcibp_pkg::cmd_t      cmd_i,
  output logic                 cmd_pop_o,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output pcibp_pkg::out_item_t out_item_o
);
  import pcibp_pkg::*;

  // buf_q holds gathered bits left-aligned; tot_q counts them. Below eight
  // bits, the top octet of buf_q is the pending octet.
  logic [BufW-1:0] buf_q, buf_d, w_buf, merged;
  logic [TotW-1:0] tot_q, tot_d, w_tot;
  logic            out_valid_q, out_valid_d;
  out_item_t       out_q, out_d;
  logic            slot_free, emit, special, idle_bits;

  always_comb begin
    slot_free = !out_valid_q || out_ready_i;
    idle_bits = tot_q < TotW'(OctetW);
    merged    = {buf_q[BufW-1 -: OctetW], WordW'(0)}
              | ({cmd_i.bits, OctetW'(0)} >> tot_q[2:0]);
    w_buf     = buf_q;
    w_tot     = tot_q;
    cmd_pop_o = 1'b0;
    emit      = 1'b0;
    special   = 1'b0;
    out_d     = out_q;

    if (idle_bits && cmd_valid_i) begin
      case (cmd_i.kind)
        KIND_APPEND: begin
          cmd_pop_o = 1'b1;
          w_buf     = merged;
          w_tot     = tot_q + TotW'(cmd_i.nbits);
        end
        KIND_ERROR: begin
          if (slot_free) begin
            cmd_pop_o = 1'b1;
            emit      = 1'b1;
            special   = 1'b1;
            out_d     = '{octet: '0, last: 1'b1, from_flush: 1'b0, range_error: 1'b1};
          end
        end
        KIND_FLUSH: begin
          if (tot_q == '0) begin
            cmd_pop_o = 1'b1;
          end else if (slot_free) begin
            cmd_pop_o = 1'b1;
            emit      = 1'b1;
            special   = 1'b1;
            out_d     = '{octet: buf_q[BufW-1 -: OctetW], last: 1'b1, from_flush: 1'b1,
                          range_error: 1'b0};
            w_buf     = '0;
            w_tot     = '0;
          end
        end
        default: begin
          cmd_pop_o = 1'b0;
        end
      endcase
    end

    buf_d = w_buf;
    tot_d = w_tot;
    if (!special && (w_tot >= TotW'(OctetW)) && slot_free) begin
      emit  = 1'b1;
      out_d = '{octet: w_buf[BufW-1 -: OctetW], last: w_tot < TotW'(2 * OctetW),
                from_flush: 1'b0, range_error: 1'b0};
      buf_d = w_buf << OctetW;
      tot_d = w_tot - TotW'(OctetW);
    end

    out_valid_d = emit ? 1'b1 : (out_ready_i ? 1'b0 : out_valid_q);
    out_valid_o = out_valid_q;
    out_item_o  = out_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      buf_q       <= '0;
      tot_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      buf_q       <= buf_d;
      tot_q       <= tot_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      out_q <= out_d;
    end
  end

  a_pop_when_drained: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_pop_o |-> tot_q < TotW'(OctetW))
    else $error("command taken while a full octet is still gathered");

  a_pending_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    tot_q < TotW'(OctetW) |-> buf_q[WordW-1:0] == '0)
    else $error("stray bits below the pending octet");

  a_more_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit && !out_d.last |=> tot_q >= TotW'(OctetW))
    else $error("octet without last but no octet left to send");

  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    tot_q < TotW'(BufW))
    else $error("bit count beyond buffer size");

endmodule

// ===== dv/tb.sv =====
// Self-checking testbench for per_constrained_integer_bit_packer: directed and random
// transactions on both valid/ready channels, checked against an in-bench octet predictor.
// Depends on pcibp_pkg and the packer RTL only.
`timescale 1ns / 100ps

module tb;
  import pcibp_pkg::*;

  localparam int CLK_PERIOD     = 8;
  localparam int IDLE_PCT       = 16;
  localparam int MAX_REPORTS    = 10;
  // Cycles without any accepted transaction before the run is declared hung.
  // A correct run never comes near this, even with long random stalls.
  localparam int WATCHDOG_LIMIT = 2000;
  // Two front stages, a four-deep command queue and the back part: anything
  // still in flight after this many quiet cycles would be a stray result.
  localparam int TAIL_CYCLES    = 24;

  // The op field has one code the block does not use; it must be ignored.
  localparam logic [1:0]  OP_UNUSED = 2'd3;
  localparam logic [31:0] INT_MIN   = 32'h8000_0000;
  localparam logic [31:0] INT_MAX   = 32'h7FFF_FFFF;

  logic      clk_i       = 1'b0;
  logic      rst_ni      = 1'b0;
  logic      in_valid_i  = 1'b0;
  logic      in_ready_o;
  in_item_t  in_item_i   = '0;
  logic      out_valid_o;
  logic      out_ready_i = 1'b0;
  out_item_t out_item_o;

  // When set, neither side idles: the block sees back-to-back traffic.
  bit steady_flow = 1'b0;

  // Predictor state: the partial octet being gathered, MSB first, and how
  // many of its bits are filled.
  logic [7:0] held_octet = '0;
  int         held_bits  = 0;

  // Octets the block still owes, oldest first.
  out_item_t expected_octets[$];

  int mismatch_count = 0;
  int quiet_cycles   = 0;

  per_constrained_integer_bit_packer uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_item_i  (in_item_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_item_o (out_item_o)
  );

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  // ---------------------------------------------------------------------------
  // Octet predictor
  // ---------------------------------------------------------------------------

  // Shift the low nbits of bits into the held octet, most significant bit
  // first, and queue every octet that fills up.
  function automatic void shift_in(input logic [31:0] bits, input int nbits);
    out_item_t full;
    for (int i = nbits - 1; i >= 0; i--) begin
      held_octet[7 - held_bits] = bits[i];
      held_bits++;
      if (held_bits == 8) begin
        full = '{octet: held_octet, last: 1'b0, from_flush: 1'b0, range_error: 1'b0};
        expected_octets.push_back(full);
        held_octet = '0;
        held_bits  = 0;
      end
    end
  endfunction

  // Work out the octets one accepted transaction causes and queue them, with
  // last marked on the final one.
  function automatic void predict_packing(input in_item_t item);
    longint      lo;
    longint      hi;
    longint      span;
    int          need;
    int          width;
    int          prior_count;
    logic [31:0] offset;
    out_item_t   entry;
    prior_count = expected_octets.size();
    case (item.op)
      OP_INT: begin
        // Bounds are ordered in 64 bits so that the full 32-bit range does
        // not overflow; the offset itself wraps modulo 2^32.
        lo = longint'($signed(item.lower_bound));
        hi = longint'($signed(item.upper_bound));
        if (lo > hi) begin
          span = lo;
          lo   = hi;
          hi   = span;
        end
        span = hi - lo + 1;
        // A single-value range carries no information and sends no bits.
        if (span > 1) begin
          need = 0;
          while ((longint'(1) << need) < span) need++;
          if (need > MaxIntBits) begin
            // Too wide: one error result, the held bits stay untouched.
            entry = '{octet: '0, last: 1'b1, from_flush: 1'b0, range_error: 1'b1};
            expected_octets.push_back(entry);
          end else begin
            offset = item.int_value - lo[31:0];
            shift_in(offset, need);
          end
        end
      end
      OP_RAW: begin
        width = item.raw_width;
        if (width > RawCap) width = RawCap;
        shift_in(item.raw_bits, width);
      end
      OP_FLUSH: begin
        // A flush of an empty octet sends nothing.
        if (held_bits > 0) begin
          entry = '{octet: held_octet, last: 1'b0, from_flush: 1'b1, range_error: 1'b0};
          expected_octets.push_back(entry);
          held_octet = '0;
          held_bits  = 0;
        end
      end
      default: begin
        // The unused op code leaves everything as it is.
      end
    endcase
    if (expected_octets.size() > prior_count) begin
      expected_octets[expected_octets.size() - 1].last = 1'b1;
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Port monitor and result checker
  // ---------------------------------------------------------------------------

  task automatic note_failure(input string what);
    mismatch_count++;
    if (mismatch_count <= MAX_REPORTS) $display("%0t: %s", $realtime, what);
  endtask

  // Both channels are sampled at the rising edge, where the values seen are
  // the ones the block registers. Inputs are predicted before outputs are
  // checked, though no result can leave in the cycle its input arrives.
  always @(posedge clk_i) begin : port_monitor
    out_item_t seen;
    out_item_t want;
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) predict_packing(in_item_i);
      if (out_valid_o && out_ready_i) begin
        seen = out_item_o;
        if (expected_octets.size() == 0) begin
          note_failure($sformatf("unexpected result: octet %02h last %0b flush %0b err %0b",
                                 seen.octet, seen.last, seen.from_flush, seen.range_error));
        end else begin
          want = expected_octets.pop_front();
          if (seen.octet !== want.octet || seen.last !== want.last ||
              seen.from_flush !== want.from_flush || seen.range_error !== want.range_error) begin
            note_failure($sformatf({"result mismatch: expected octet %02h last %0b flush %0b ",
                                    "err %0b, got octet %02h last %0b flush %0b err %0b"},
                                   want.octet, want.last, want.from_flush, want.range_error,
                                   seen.octet, seen.last, seen.from_flush, seen.range_error));
          end
        end
      end
    end
  end

  // The receiver stalls in about one cycle of six unless steady flow is on.
  always @(posedge clk_i) begin
    out_ready_i <= steady_flow || ($urandom_range(99) >= IDLE_PCT);
  end

  // Watchdog: a hang shows up as a long run of cycles with no transaction on
  // either channel.
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------

  // Fields an operation does not use are filled with noise; the block must
  // not look at them.
  function automatic in_item_t int_item(input logic [31:0] value, input logic [31:0] lo,
                                        input logic [31:0] hi);
    in_item_t item;
    item.op          = OP_INT;
    item.int_value   = value;
    item.lower_bound = lo;
    item.upper_bound = hi;
    item.raw_bits    = $urandom;
    item.raw_width   = 6'($urandom);
    return item;
  endfunction

  function automatic in_item_t raw_item(input logic [31:0] bits, input logic [5:0] width);
    in_item_t item;
    item.op          = OP_RAW;
    item.int_value   = $urandom;
    item.lower_bound = $urandom;
    item.upper_bound = $urandom;
    item.raw_bits    = bits;
    item.raw_width   = width;
    return item;
  endfunction

  function automatic in_item_t bare_item(input logic [1:0] op);
    in_item_t item;
    item.op          = op;
    item.int_value   = $urandom;
    item.lower_bound = $urandom;
    item.upper_bound = $urandom;
    item.raw_bits    = $urandom;
    item.raw_width   = 6'($urandom);
    return item;
  endfunction

  // Present one transaction and return in the step it is accepted. It is
  // entered just after a rising edge; valid stays high on return so that a
  // following transaction can go out back to back.
  task automatic send_item(input in_item_t item);
    while (!steady_flow && $urandom_range(99) < IDLE_PCT) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_item_i  <= item;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Constrained integers at the edges of the bounds and of the field width.
  task automatic test_integer_fields();
    // Full 32-bit range needs far more than the field allows.
    send_item(int_item(32'd0, INT_MIN, INT_MAX));
    // Equal bounds send nothing.
    send_item(int_item(-32'sd7, -32'sd7, -32'sd7));
    // Exactly the widest legal field, all ones.
    send_item(int_item(32'h000F_FFFF, 32'd0, 32'h000F_FFFF));
    // One value more than the widest legal field.
    send_item(int_item(-32'sd1000, -32'sd1000, -32'sd1000 + 32'h0010_0000));
    // Reversed bounds get swapped.
    send_item(int_item(-32'sd37, 32'sd100, -32'sd100));
    // Two-value range at the top of the number line.
    send_item(int_item(INT_MAX, INT_MAX - 1, INT_MAX));
    // Values outside the bounds wrap around.
    send_item(int_item(INT_MIN, 32'sd5, 32'sd20));
    send_item(int_item(INT_MAX, INT_MIN, INT_MIN + 1000));
    // Reversed bounds at the top, value far below them.
    send_item(int_item(32'd0, INT_MAX, INT_MAX - 12));
  endtask

  // Raw strings of zero, short, full and oversized widths.
  task automatic test_raw_strings();
    send_item(raw_item(32'hFFFF_FFFF, 6'd0));
    send_item(raw_item(32'h0000_0001, 6'd1));
    send_item(raw_item(32'h0000_0055, 6'd7));
    send_item(raw_item(32'hFFFF_FFFF, 6'd32));
    // Widths above 32 saturate to 32.
    send_item(raw_item(32'hA5A5_5A5A, 6'd63));
    send_item(raw_item(32'h0000_0000, 6'd33));
    send_item(raw_item(32'h0000_003C, 6'd8));
  endtask

  // Flushes with and without held bits, the unused op code, and the largest
  // burst: seven held bits plus a full word give four octets from one input.
  task automatic test_flush_and_unused();
    send_item(bare_item(OP_FLUSH));
    send_item(bare_item(OP_FLUSH));
    send_item(bare_item(OP_UNUSED));
    send_item(raw_item(32'h0000_007F, 6'd7));
    send_item(raw_item(32'h8001_C3E7, 6'd32));
    send_item(bare_item(OP_FLUSH));
  endtask

  // Random mix of operations. Integer ranges are mostly small, some sit at
  // the width limit and a few are wide enough to be rejected. Transactions
  // with the unused op are sent as noise but not counted.
  task automatic test_random_traffic(input int count);
    int          sent;
    int          pick;
    logic [31:0] lo;
    logic [31:0] span;
    logic [31:0] value;
    logic [5:0]  width;
    in_item_t    item;
    sent = 0;
    while (sent < count) begin
      pick = $urandom_range(99);
      if (pick < 40) begin
        lo   = $urandom;
        pick = $urandom_range(99);
        if (pick < 70) span = $urandom_range(255);
        else if (pick < 80) span = 32'h000F_FFFF + $urandom_range(1);
        else if (pick < 90) span = $urandom_range(32'h0010_0000);
        else span = $urandom;
        value = ($urandom_range(99) < 80) ? lo + $urandom_range(span) : $urandom;
        if ($urandom_range(1)) item = int_item(value, lo + span, lo);
        else item = int_item(value, lo, lo + span);
      end else if (pick < 75) begin
        width = ($urandom_range(99) < 85) ? 6'($urandom_range(32)) : 6'($urandom_range(63, 33));
        item  = raw_item($urandom, width);
      end else if (pick < 95) begin
        item = bare_item(OP_FLUSH);
      end else begin
        item = bare_item(OP_UNUSED);
      end
      send_item(item);
      if (item.op != OP_UNUSED) sent++;
    end
  endtask

  // Same mix with no idling on either side, so that the queue runs full
  // speed and the back part is never paused by the receiver.
  task automatic test_back_to_back(input int count);
    steady_flow = 1'b1;
    test_random_traffic(count);
    steady_flow = 1'b0;
  endtask

  initial begin
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_integer_fields();
    test_raw_strings();
    test_flush_and_unused();
    test_random_traffic(100);
    test_back_to_back(40);
    test_random_traffic(50);

    in_valid_i <= 1'b0;
    while (expected_octets.size() != 0) @(posedge clk_i);
    repeat (TAIL_CYCLES) @(posedge clk_i);

    if (mismatch_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
